### rtl/fuzzy_rule_scorer_with_lms_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fuzzy rule scorer
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FUZZY_RULE_SCORER_WITH_LMS_UPDATE_ASSERT_SVH
`define FUZZY_RULE_SCORER_WITH_LMS_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// Check held out of reset.
`define FRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frs assertion failed");
// Check that also holds during reset.
`define FRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frs assertion failed");
`else
`define FRS_ASSERT(lbl, prop)
`define FRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants, types and the sigmoid table of the fuzzy rule scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package frs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SIG_DEPTH = 256;
  localparam int SIG_AW    = $clog2(SIG_DEPTH);
  localparam int NRULES    = 12;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int T2        = (2 * ONE + 5) / 10;
  localparam int T3        = (3 * ONE + 5) / 10;
  localparam int T4        = (4 * ONE + 5) / 10;
  localparam int T5        = (5 * ONE + 5) / 10;
  localparam int T6        = (6 * ONE + 5) / 10;
  localparam int T7        = (7 * ONE + 5) / 10;
  localparam int T8        = (8 * ONE + 5) / 10;
  localparam int W_MIN     = (ONE + 50) / 100;
  localparam int W_MAX     = 10 * ONE;
  localparam int RATE_MIN  = (ONE + 500) / 1000;
  localparam int RATE_MAX  = ONE / 2;
  localparam int RATE_RST  = (ONE * 5 + 50) / 100;

  localparam int NUM_W     = 41;  // sum of 12 weight*activation products
  localparam int DEN_W     = 20;  // sum of 12 activations
  localparam int QUO_W     = 21;  // quotient is at most W_MAX

  typedef enum logic [1:0] {
    ACT_PREDICT = 2'd0,
    ACT_LEARN   = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_SPARE   = 2'd3
  } action_t;

  localparam logic [3:0] SLOT_BIAS = 4'd12;

  // membership select per rule: 0 low, 1 medium, 2 high (feature 0,1,2)
  typedef logic [1:0] msel_t [3];
  typedef msel_t rule_tab_t [NRULES];
  localparam rule_tab_t RULE_SEL = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd0, 2'd2},
    '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd1}, '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd1, 2'd1}, '{2'd1, 2'd2, 2'd2}, '{2'd2, 2'd2, 2'd2}
  };

  typedef logic [16:0] sig_tab_t [SIG_DEPTH];

  // shift-subtract long division, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // signed division truncating toward zero
  function automatic longint sdiv64(longint n, longint d);
    longint unsigned q;
    q = udiv64(longint'(n < 0 ? -n : n), longint'(d < 0 ? -d : d));
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Entry k = sigmoid(5k/(DEPTH-1)) in Q16, via a Q30 series for e^-y.
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t          tab;
    longint unsigned   y, n, r, den, q30;
    longint            f, term, sum;
    q30 = 64'd1 << 30;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      y = udiv64((longint'(5) * k) << 30, longint'(SIG_DEPTH - 1));
      n = y >> 30;
      f = longint'(y & (q30 - 1));
      term = longint'(q30);
      sum  = longint'(q30);
      for (int i = 1; i <= 14; i++) begin
        term = sdiv64(term * -f, longint'(i) * longint'(q30));
        sum  = sum + term;
      end
      r = longint'(sum);
      for (longint unsigned j = 0; j < n; j++) begin
        r = (r * 64'd395007542 + (64'd1 << 29)) >> 30;
      end
      den = q30 + r;
      tab[k] = 17'(udiv64((64'd1 << (30 + FRAC_BITS)) + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  typedef struct packed {
    logic       capture;   // latch input transaction
    logic       acc;       // accumulate rule idx
    logic       dload;     // load divider
    logic       div;       // one divider step
    logic       score;     // form score and table index
    logic       rate;      // form error (learn only)
    logic       step;      // form base weight step
    logic       upd;       // update weight idx
    logic       fin_learn; // commit bias and statistics
    logic       fin_write; // commit slot write
    logic       load_out;  // load output register
    logic [3:0] idx;
  } frs_cmd_t;

  typedef struct packed {
    logic out_free;
  } frs_sts_t;

  typedef struct packed {
    logic [47:0] error_total;
    logic [31:0] update_total;
    logic [17:0] outcome_error;
    logic [16:0] close_prob;
    logic [16:0] lead_score;
  } frs_res_t;

endpackage

### rtl/fuzzy_rule_scorer_with_lms_update.sv
// ----------------------------------------------------------------------------
// fuzzy_rule_scorer_with_lms_update
// Zero-order Sugeno scorer over three features with LMS weight adaptation.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one item at a time. After acceptance
// a predict or write item runs the rule multiply-accumulate (a 20x17
// multiplier), a divider load, a restoring divider for weighted sum over
// activation sum, then score with sigmoid index, error (learn only), commit
// and output load, and returns to the idle state that accepts. A learn item
// adds the base step and the weight updates (the same rule index walks the
// weights) before commit. The output register lets the next item start
// while a result waits; a second result stalls the sequencer and the input.
// learn_rate is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this.
// All values are Q16. Memberships: low (0,.2,.4), medium (.3,.5,.7)
// triangles, high a ramp from .6 to .8 held at 1 through 1.0.
`timescale 1ns / 1ps
`include "fuzzy_rule_scorer_with_lms_update_assert.svh"
module fuzzy_rule_scorer_with_lms_update import frs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // engagement[17:0], intention[35:18], conf_level[53:36],
  // target_outcome[70:54], slot_index[74:71], slot_value[95:75]
  input  logic [95:0]   in_tdata,
  // action[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // lead_score[16:0], close_prob[33:17], outcome_error[51:34],
  // update_total[83:52], error_total[131:84], zero pad[135:132]
  output logic [135:0]  out_tdata,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data
);

  frs_cmd_t cmd;
  frs_sts_t sts;
  frs_res_t res;

  frs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  frs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .engagement     ($signed(in_tdata[17:0])),
    .intention      ($signed(in_tdata[35:18])),
    .conf_level     ($signed(in_tdata[53:36])),
    .target_outcome (in_tdata[70:54]),
    .slot_index     (in_tdata[74:71]),
    .slot_value     ($signed(in_tdata[95:75])),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_res        (res)
  );

  assign out_tdata = {4'b0000, res};

  // busy after every accepted transaction
  `FRS_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready)
  // score stays within [0,1]
  `FRS_ASSERT(a_score_range, out_tvalid |-> (out_tdata[16:0] <= 17'd65536))
  // sigmoid of a nonnegative score is at least one half
  `FRS_ASSERT(a_prob_half, out_tvalid |-> (out_tdata[33:17] >= 17'd32768))

endmodule

### rtl/frs_ctrl.sv
// ----------------------------------------------------------------------------
// frs_ctrl
// Sequencer: accumulate, divide, score, weight update, commit, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module frs_ctrl import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic [1:0] in_action,
  input  frs_sts_t sts,
  output frs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_DLOAD, S_DIV, S_SCORE, S_RATE, S_STEP, S_UPD, S_FIN, S_OUT
  } state_t;

  state_t      state_r;
  logic [4:0]  cnt_r;
  action_t     act_r;

  assign in_tready = rst_n && (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.idx       = cnt_r[3:0];
    cmd.capture   = in_tready && in_tvalid;
    cmd.acc       = (state_r == S_ACC);
    cmd.dload     = (state_r == S_DLOAD);
    cmd.div       = (state_r == S_DIV);
    cmd.score     = (state_r == S_SCORE);
    cmd.rate      = (state_r == S_RATE) && (act_r == ACT_LEARN);
    cmd.step      = (state_r == S_STEP);
    cmd.upd       = (state_r == S_UPD);
    cmd.fin_learn = (state_r == S_FIN) && (act_r == ACT_LEARN);
    cmd.fin_write = (state_r == S_FIN) && (act_r == ACT_WRITE);
    cmd.load_out  = (state_r == S_OUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      act_r   <= ACT_PREDICT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r   <= action_t'(in_action);
            cnt_r   <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (cnt_r == 5'(NRULES - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DLOAD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_DLOAD: state_r <= S_DIV;
        S_DIV: begin
          if (cnt_r == 5'(QUO_W - 1)) begin
            cnt_r   <= '0;
            state_r <= S_SCORE;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SCORE: state_r <= S_RATE;
        S_RATE:  state_r <= (act_r == ACT_LEARN) ? S_STEP : S_FIN;
        S_STEP:  state_r <= S_UPD;
        S_UPD: begin
          if (cnt_r == 5'(NRULES - 1)) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/frs_datapath.sv
// ----------------------------------------------------------------------------
// frs_datapath
// Memberships, rule MAC, restoring divider, sigmoid lookup, LMS update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module frs_datapath import frs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  frs_cmd_t            cmd,
  output frs_sts_t            sts,
  input  logic signed [17:0]  engagement,
  input  logic signed [17:0]  intention,
  input  logic signed [17:0]  conf_level,
  input  logic [16:0]         target_outcome,
  input  logic [3:0]          slot_index,
  input  logic signed [20:0]  slot_value,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frs_res_t            out_res
);

  // All membership slopes span 13107 = (ONE-1)/5, so a ramp is exactly 5*d.
  function automatic logic [16:0] mf_tri(logic [16:0] x, int a, int b, int c);
    if (x <= 17'(a) || x >= 17'(c)) return '0;
    if (x == 17'(b)) return 17'(ONE);
    if (x < 17'(b)) return 17'(5 * (x - 17'(a)));
    return 17'(5 * (17'(c) - x));
  endfunction

  function automatic logic [16:0] mf_high(logic [16:0] x);
    if (x <= 17'(T6)) return '0;
    if (x >= 17'(T8)) return 17'(ONE);
    return 17'(5 * (x - 17'(T6)));
  endfunction

  function automatic logic [16:0] clip01(logic signed [17:0] v);
    if (v < 0) return '0;
    if (v > 18'sd65536) return 17'(ONE);
    return 17'(v);
  endfunction

  logic [16:0]        feat_r [3];
  logic [16:0]        tgt_r;
  logic [3:0]         slot_r;
  logic signed [20:0] sval_r;
  logic [15:0]        rate_r;
  logic [19:0]        w_r [NRULES];
  logic signed [17:0] bias_r;
  logic [31:0]        ucnt_r;
  logic [47:0]        esum_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [16:0]        score_r;
  logic [SIG_AW-1:0]  sidx_r;
  logic signed [17:0] err_r;
  logic [16:0]        mag_r;
  logic [16:0]        t_r;
  logic               neg_r;
  logic               out_valid_r;
  frs_res_t           res_r;

  logic [16:0] mf [3][3];
  logic [16:0] act;
  logic [16:0] a0, a1, a2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mf[j][0] = mf_tri(feat_r[j], 0, T2, T4);
      mf[j][1] = mf_tri(feat_r[j], T3, T5, T7);
      mf[j][2] = mf_high(feat_r[j]);
    end
    a0  = mf[0][RULE_SEL[cmd.idx][0]];
    a1  = mf[1][RULE_SEL[cmd.idx][1]];
    a2  = mf[2][RULE_SEL[cmd.idx][2]];
    act = a0;
    if (a1 < act) act = a1;
    if (a2 < act) act = a2;
  end

  // divider step
  logic [DEN_W:0] div_sh;
  logic           div_ge;
  assign div_sh = {rem_r, quo_r[QUO_W-1]};
  assign div_ge = (div_sh >= {1'b0, den_r});

  // score
  logic [QUO_W-1:0]   qv;
  logic signed [22:0] ssum;
  logic [16:0]        score_c;
  logic [25:0]        sidx_full;
  assign qv   = (den_r == '0) ? QUO_W'(HALF) : quo_r;
  assign ssum = $signed({2'b00, qv}) + 23'(bias_r);
  assign score_c = (ssum < 0) ? '0 : (ssum > 23'sd65536) ? 17'(ONE) : 17'(ssum);
  assign sidx_full = 26'(score_c) * 26'(SIG_DEPTH - 1) + 26'(HALF);

  // error and base step
  logic [16:0]        tgt_c;
  logic [15:0]        rate_c;
  logic signed [17:0] err_c;
  logic [16:0]        mag_c;
  logic [32:0]        t_full;
  assign tgt_c  = (tgt_r > 17'(ONE)) ? 17'(ONE) : tgt_r;
  assign rate_c = (rate_r < 16'(RATE_MIN)) ? 16'(RATE_MIN) :
                  (rate_r > 16'(RATE_MAX)) ? 16'(RATE_MAX) : rate_r;
  assign err_c  = $signed({1'b0, tgt_c}) - $signed({1'b0, score_r});
  assign mag_c  = err_c[17] ? 17'(-err_c) : 17'(err_c);
  assign t_full = 33'(rate_c) * 33'(mag_r) + 33'(HALF);

  // per-rule weight step
  logic [33:0]        step_full;
  logic signed [21:0] wn;
  logic [19:0]        wn_c;
  assign step_full = 34'(t_r) * 34'(act) + 34'(HALF);
  assign wn   = neg_r ? 22'(w_r[cmd.idx]) - 22'(step_full[33:16])
                      : 22'(w_r[cmd.idx]) + 22'(step_full[33:16]);
  assign wn_c = (wn < 22'(W_MIN)) ? 20'(W_MIN) : (wn > 22'(W_MAX)) ? 20'(W_MAX) : 20'(wn);

  // bias step and slot write
  logic signed [18:0] bn;
  logic signed [17:0] bn_c;
  logic [19:0]        sw_c;
  logic signed [17:0] sb_c;
  logic [48:0]        esum_n;
  assign bn   = neg_r ? 19'(bias_r) - 19'(t_r) : 19'(bias_r) + 19'(t_r);
  assign bn_c = (bn < -19'sd65536) ? -18'sd65536 : (bn > 19'sd65536) ? 18'sd65536 : 18'(bn);
  assign sw_c = (sval_r < 21'(W_MIN)) ? 20'(W_MIN) :
                (sval_r > 21'(W_MAX)) ? 20'(W_MAX) : 20'(sval_r);
  assign sb_c = (sval_r < -21'sd65536) ? -18'sd65536 :
                (sval_r > 21'sd65536) ? 18'sd65536 : 18'(sval_r);
  assign esum_n = 49'(esum_r) + 49'(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 16'(RATE_RST);
      for (int k = 0; k < NRULES; k++) w_r[k] <= 20'(ONE);
      bias_r      <= '0;
      ucnt_r      <= '0;
      esum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) rate_r <= cfg_wr_data;
      if (cmd.upd) w_r[cmd.idx] <= wn_c;
      if (cmd.fin_learn) begin
        bias_r <= bn_c;
        if (ucnt_r != '1) ucnt_r <= ucnt_r + 32'd1;
        esum_r <= esum_n[48] ? '1 : esum_n[47:0];
      end
      if (cmd.fin_write) begin
        if (slot_r < 4'(NRULES)) w_r[slot_r] <= sw_c;
        else if (slot_r == SLOT_BIAS) bias_r <= sb_c;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      feat_r[0] <= clip01(engagement);
      feat_r[1] <= clip01(intention);
      feat_r[2] <= clip01(conf_level);
      tgt_r     <= target_outcome;
      slot_r    <= slot_index;
      sval_r    <= slot_value;
      num_r     <= '0;
      den_r     <= '0;
    end
    if (cmd.acc) begin
      num_r <= num_r + NUM_W'(37'(w_r[cmd.idx]) * 37'(act));
      den_r <= den_r + DEN_W'(act);
    end
    if (cmd.dload) begin
      rem_r <= num_r[NUM_W-1:QUO_W];
      quo_r <= num_r[QUO_W-1:0];
    end
    if (cmd.div) begin
      rem_r <= div_ge ? DEN_W'(div_sh - {1'b0, den_r}) : div_sh[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
    end
    if (cmd.score) begin
      score_r <= score_c;
      sidx_r  <= (sidx_full[25:16] > 10'(SIG_DEPTH - 1)) ? SIG_AW'(SIG_DEPTH - 1)
                                                         : SIG_AW'(sidx_full[25:16]);
      err_r   <= '0;
      mag_r   <= '0;
    end
    if (cmd.rate) begin
      err_r <= err_c;
      mag_r <= mag_c;
      neg_r <= err_c[17];
    end
    // base step from the registered error magnitude
    if (cmd.step) t_r <= t_full[32:16];
    if (cmd.load_out) begin
      res_r.lead_score    <= score_r;
      res_r.close_prob    <= SIG_TAB[sidx_r];
      res_r.outcome_error <= err_r;
      res_r.update_total  <= ucnt_r;
      res_r.error_total   <= esum_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_res      = res_r;

endmodule
